>>> src/acrg_pkg.sv
// Shared types, constants and AES helper functions for the counter-mode generator.
`timescale 1ns / 1ps
`default_nettype none
package acrg_pkg;

  localparam int BLOCK_BYTES = 16;

  typedef enum logic [0:0] {
    OP_INSTANTIATE = 1'b0,
    OP_GENERATE    = 1'b1
  } op_t;

  typedef enum logic [1:0] {
    CFG_KEY_UPPER    = 2'd0,
    CFG_KEY_LOWER    = 2'd1,
    CFG_COUNTER_SEED = 2'd2
  } cfg_idx_t;

  typedef enum logic [1:0] {
    ST_IDLE  = 2'd0,
    ST_START = 2'd1,
    ST_ROUND = 2'd2,
    ST_OUT   = 2'd3
  } state_t;

  // Handshake between sequencer and round unit
  typedef struct packed {
    logic start;
    logic busy;
    logic done;
  } aes_ctl_t;

  function automatic logic [7:0] sbox(input logic [7:0] a);
    logic [7:0] t [256];
    t = '{
      8'h63,8'h7c,8'h77,8'h7b,8'hf2,8'h6b,8'h6f,8'hc5,8'h30,8'h01,8'h67,8'h2b,8'hfe,8'hd7,8'hab,8'h76,
      8'hca,8'h82,8'hc9,8'h7d,8'hfa,8'h59,8'h47,8'hf0,8'had,8'hd4,8'ha2,8'haf,8'h9c,8'ha4,8'h72,8'hc0,
      8'hb7,8'hfd,8'h93,8'h26,8'h36,8'h3f,8'hf7,8'hcc,8'h34,8'ha5,8'he5,8'hf1,8'h71,8'hd8,8'h31,8'h15,
      8'h04,8'hc7,8'h23,8'hc3,8'h18,8'h96,8'h05,8'h9a,8'h07,8'h12,8'h80,8'he2,8'heb,8'h27,8'hb2,8'h75,
      8'h09,8'h83,8'h2c,8'h1a,8'h1b,8'h6e,8'h5a,8'ha0,8'h52,8'h3b,8'hd6,8'hb3,8'h29,8'he3,8'h2f,8'h84,
      8'h53,8'hd1,8'h00,8'hed,8'h20,8'hfc,8'hb1,8'h5b,8'h6a,8'hcb,8'hbe,8'h39,8'h4a,8'h4c,8'h58,8'hcf,
      8'hd0,8'hef,8'haa,8'hfb,8'h43,8'h4d,8'h33,8'h85,8'h45,8'hf9,8'h02,8'h7f,8'h50,8'h3c,8'h9f,8'ha8,
      8'h51,8'ha3,8'h40,8'h8f,8'h92,8'h9d,8'h38,8'hf5,8'hbc,8'hb6,8'hda,8'h21,8'h10,8'hff,8'hf3,8'hd2,
      8'hcd,8'h0c,8'h13,8'hec,8'h5f,8'h97,8'h44,8'h17,8'hc4,8'ha7,8'h7e,8'h3d,8'h64,8'h5d,8'h19,8'h73,
      8'h60,8'h81,8'h4f,8'hdc,8'h22,8'h2a,8'h90,8'h88,8'h46,8'hee,8'hb8,8'h14,8'hde,8'h5e,8'h0b,8'hdb,
      8'he0,8'h32,8'h3a,8'h0a,8'h49,8'h06,8'h24,8'h5c,8'hc2,8'hd3,8'hac,8'h62,8'h91,8'h95,8'he4,8'h79,
      8'he7,8'hc8,8'h37,8'h6d,8'h8d,8'hd5,8'h4e,8'ha9,8'h6c,8'h56,8'hf4,8'hea,8'h65,8'h7a,8'hae,8'h08,
      8'hba,8'h78,8'h25,8'h2e,8'h1c,8'ha6,8'hb4,8'hc6,8'he8,8'hdd,8'h74,8'h1f,8'h4b,8'hbd,8'h8b,8'h8a,
      8'h70,8'h3e,8'hb5,8'h66,8'h48,8'h03,8'hf6,8'h0e,8'h61,8'h35,8'h57,8'hb9,8'h86,8'hc1,8'h1d,8'h9e,
      8'he1,8'hf8,8'h98,8'h11,8'h69,8'hd9,8'h8e,8'h94,8'h9b,8'h1e,8'h87,8'he9,8'hce,8'h55,8'h28,8'hdf,
      8'h8c,8'ha1,8'h89,8'h0d,8'hbf,8'he6,8'h42,8'h68,8'h41,8'h99,8'h2d,8'h0f,8'hb0,8'h54,8'hbb,8'h16
    };
    return t[a];
  endfunction

  function automatic logic [7:0] xtime(input logic [7:0] b);
    return {b[6:0], 1'b0} ^ (b[7] ? 8'h1b : 8'h00);
  endfunction

endpackage
`default_nettype wire

>>> src/acrg_aes_core.sv
// Iterative AES-128 engine: one round and one key schedule step per cycle.
`timescale 1ns / 1ps
`default_nettype none
module acrg_aes_core
  import acrg_pkg::*;
(
  input  wire logic         clk,
  input  wire logic         rst_n,
  input  wire logic         start,
  input  wire logic [127:0] key,
  input  wire logic [127:0] pt,
  output logic [127:0]      ct,
  output aes_ctl_t          ctl
);

  logic [127:0] st_r, st_nxt;
  logic [127:0] rk_r, rk_nxt;
  logic [3:0]   rnd_r, rnd_nxt;
  logic [7:0]   rcon_r, rcon_nxt;
  logic         busy_r, busy_nxt;
  logic         done_r, done_nxt;
  logic [7:0]   sb [16];
  logic [7:0]   mc [16];
  logic [31:0]  tw;
  logic [127:0] nk;
  logic [127:0] rnd_out;

  // Byte i of a 128-bit word sits at bits [127-8i -: 8]
  always_comb begin
    for (int c = 0; c < 4; c++) begin
      for (int r = 0; r < 4; r++) begin
        sb[r + 4*c] = sbox(st_r[127 - 8*(r + 4*((c + r) % 4)) -: 8]);
      end
    end
    for (int c = 0; c < 4; c++) begin
      logic [7:0] a0, a1, a2, a3, al;
      a0 = sb[4*c]; a1 = sb[4*c+1]; a2 = sb[4*c+2]; a3 = sb[4*c+3];
      al = a0 ^ a1 ^ a2 ^ a3;
      mc[4*c]   = (rnd_r == 4'd10) ? a0 : a0 ^ al ^ xtime(a0 ^ a1);
      mc[4*c+1] = (rnd_r == 4'd10) ? a1 : a1 ^ al ^ xtime(a1 ^ a2);
      mc[4*c+2] = (rnd_r == 4'd10) ? a2 : a2 ^ al ^ xtime(a2 ^ a3);
      mc[4*c+3] = (rnd_r == 4'd10) ? a3 : a3 ^ al ^ xtime(a3 ^ a0);
    end
    // Next round key
    tw = {sbox(rk_r[23:16]) ^ rcon_r, sbox(rk_r[15:8]), sbox(rk_r[7:0]), sbox(rk_r[31:24])};
    nk[127:96] = rk_r[127:96] ^ tw;
    nk[95:64]  = rk_r[95:64] ^ nk[127:96];
    nk[63:32]  = rk_r[63:32] ^ nk[95:64];
    nk[31:0]   = rk_r[31:0] ^ nk[63:32];
    for (int i = 0; i < 16; i++) begin
      rnd_out[127 - 8*i -: 8] = mc[i] ^ nk[127 - 8*i -: 8];
    end
  end

  // Sequence rounds
  always_comb begin
    st_nxt = st_r; rk_nxt = rk_r; rnd_nxt = rnd_r; rcon_nxt = rcon_r;
    busy_nxt = busy_r; done_nxt = 1'b0;
    if (start && !busy_r) begin
      st_nxt = pt ^ key; rk_nxt = key; rnd_nxt = 4'd1; rcon_nxt = 8'h01;
      busy_nxt = 1'b1;
    end else if (busy_r) begin
      st_nxt = rnd_out; rk_nxt = nk; rcon_nxt = xtime(rcon_r);
      rnd_nxt = rnd_r + 4'd1;
      if (rnd_r == 4'd10) begin
        busy_nxt = 1'b0; done_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    st_r <= st_nxt; rk_r <= rk_nxt; rnd_r <= rnd_nxt; rcon_r <= rcon_nxt;
    if (!rst_n) begin
      busy_r <= 1'b0; done_r <= 1'b0;
    end else begin
      busy_r <= busy_nxt; done_r <= done_nxt;
    end
  end

  assign ct        = st_r;
  assign ctl.start = start;
  assign ctl.busy  = busy_r;
  assign ctl.done  = done_r;

`ifndef SYNTHESIS
  a_done_after_busy: assert property (@(posedge clk) disable iff (!rst_n)
    done_r |-> $past(busy_r)) else $error("done without busy");
  a_no_busy_done: assert property (@(posedge clk) disable iff (!rst_n)
    !(done_r && busy_r)) else $error("done while busy");
  a_busy_start: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(busy_r) |-> $past(start)) else $error("busy without start");
`endif

endmodule
`default_nettype wire

>>> src/aes_counter_mode_random_generator_core.sv
// Top level: request sequencer, counter, key registers and output word register.
//
// Each generate request of N bytes (saturated to MAX_REQUEST_BYTES) yields ceil(N/16)
// output words. The request is accepted in idle; then each word passes through the
// counter step, the launch of the round unit, ten AES rounds, done and hand-off, plus
// any wait on out_tready. An instantiate or a zero-byte request is only accepted and
// gives no output. in_tready is low while a request is in work.
`timescale 1ns / 1ps
`default_nettype none
module aes_counter_mode_random_generator_core
  import acrg_pkg::*;
#(
  parameter int MAX_REQUEST_BYTES = 1024
) (
  input  wire logic         clk,
  input  wire logic         rst_n,
  input  wire logic         in_tvalid,
  output logic              in_tready,
  input  wire logic [15:0]  in_tdata,   // [0] operation, [11:1] byte_count
  output logic              out_tvalid,
  input  wire logic         out_tready,
  output logic [135:0]      out_tdata,  // [63:0] block_upper, [127:64] block_lower,
                                        // [132:128] valid_bytes
  output logic              out_tlast,  // last_block
  input  wire logic         cfg_we,
  input  wire logic [1:0]   cfg_index,
  input  wire logic [63:0]  cfg_wdata
);

  logic [63:0]  key_up_r, key_lo_r;
  logic [15:0]  seed_r;
  logic [127:0] ctr_r, ctr_nxt;
  logic [10:0]  rem_r, rem_nxt;
  state_t       state_r, state_nxt;
  logic         ov_r, ov_nxt;
  logic [127:0] ob_r, ob_nxt;
  logic [4:0]   ovb_r, ovb_nxt;
  logic         olast_r, olast_nxt;
  logic [127:0] ct;
  aes_ctl_t     actl;
  logic [10:0]  req;
  logic         aes_start;

  assign req = (in_tdata[11:1] > 11'(MAX_REQUEST_BYTES)) ? 11'(MAX_REQUEST_BYTES) : in_tdata[11:1];

  acrg_aes_core u_aes (
    .clk(clk), .rst_n(rst_n), .start(aes_start), .key({key_up_r, key_lo_r}),
    .pt(ctr_r), .ct(ct), .ctl(actl)
  );

  // Configuration writes
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      key_up_r <= '0; key_lo_r <= '0; seed_r <= '0;
    end else if (cfg_we) begin
      case (cfg_index)
        CFG_KEY_UPPER:    key_up_r <= cfg_wdata;
        CFG_KEY_LOWER:    key_lo_r <= cfg_wdata;
        CFG_COUNTER_SEED: seed_r   <= cfg_wdata[15:0];
        default: ;
      endcase
    end
  end

  // Next state
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      ST_IDLE: if (in_tvalid && op_t'(in_tdata[0]) == OP_GENERATE && req != 11'd0)
                 state_nxt = ST_START;
      ST_START: state_nxt = ST_ROUND;
      ST_ROUND: if (actl.done) state_nxt = ST_OUT;
      ST_OUT: if (!ov_r || out_tready)
                state_nxt = (rem_r <= 11'd16) ? ST_IDLE : ST_START;
      default: state_nxt = ST_IDLE;
    endcase
  end

  // Datapath and outputs
  always_comb begin
    ctr_nxt = ctr_r; rem_nxt = rem_r; ob_nxt = ob_r; ovb_nxt = ovb_r;
    olast_nxt = olast_r; ov_nxt = ov_r; aes_start = 1'b0;
    in_tready = (state_r == ST_IDLE);
    if (ov_r && out_tready) ov_nxt = 1'b0;
    case (state_r)
      ST_IDLE: if (in_tvalid) begin
        if (op_t'(in_tdata[0]) == OP_INSTANTIATE) ctr_nxt = {112'd0, seed_r};
        else rem_nxt = req;
      end
      ST_START: begin
        ctr_nxt = ctr_r + 128'd1;
      end
      ST_ROUND: aes_start = !actl.busy && !actl.done;
      ST_OUT: if (!ov_r || out_tready) begin
        ov_nxt = 1'b1; ob_nxt = ct;
        ovb_nxt = (rem_r > 11'd16) ? 5'd16 : rem_r[4:0];
        rem_nxt = (rem_r > 11'd16) ? rem_r - 11'd16 : 11'd0;
        olast_nxt = (rem_r <= 11'd16);
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    rem_r <= rem_nxt; ob_r <= ob_nxt; ovb_r <= ovb_nxt; olast_r <= olast_nxt;
    if (!rst_n) begin
      state_r <= ST_IDLE; ov_r <= 1'b0; ctr_r <= '0;
    end else begin
      state_r <= state_nxt; ov_r <= ov_nxt; ctr_r <= ctr_nxt;
    end
  end

  assign out_tvalid = ov_r;
  assign out_tdata  = {3'd0, ovb_r, ob_r[63:0], ob_r[127:64]};
  assign out_tlast  = olast_r;

`ifndef SYNTHESIS
  a_ready_idle: assert property (@(posedge clk) disable iff (!rst_n)
    in_tready |-> state_r == ST_IDLE) else $error("ready outside idle");
  a_vb_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> (ovb_r != 5'd0 && ovb_r <= 5'd16)) else $error("valid_bytes range");
  a_partial_last: assert property (@(posedge clk) disable iff (!rst_n)
    (out_tvalid && ovb_r != 5'd16) |-> out_tlast) else $error("partial not last");
`endif

endmodule
`default_nettype wire
